@@ design/slot_pool_allocate_sort_macros.svh @@
// Assertion helpers for the slot pool checks.
// Each macro samples on the rising clock edge and is quiet while reset is high.
`ifndef SLOT_POOL_ALLOCATE_SORT_MACROS_SVH
`define SLOT_POOL_ALLOCATE_SORT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define SPAS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("slot pool check failed");

// Check a consequent in the cycle after its antecedent.
`define SPAS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("slot pool check failed");

`endif

@@ design/spas_pkg.sv @@
package spas_pkg;

   // Free marker held by an empty slot
   localparam logic [3:0] FREE_TAG = 4'd15;

   // Request command codes
   typedef enum logic [2:0] {
      CMD_CLEAR   = 3'd0,
      CMD_ALLOC   = 3'd1,
      CMD_RELEASE = 3'd2,
      CMD_SORT    = 3'd3,
      CMD_READ    = 3'd4
   } cmd_code_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ONE,
      ST_SCAN,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_SWAP_C,
      ST_SWAP_D,
      ST_NEXT,
      ST_POS_RD,
      ST_POS_EM
   } state_type;

   // Read address source
   typedef enum logic [1:0] {
      RD_IDX,
      RD_I,
      RD_BEST,
      RD_POS
   } rd_sel_type;

   // Tag table write source
   typedef enum logic [1:0] {
      WT_NONE,
      WT_ALLOC,
      WT_I,
      WT_BEST
   } wt_sel_type;

   // Origin table write source
   typedef enum logic [1:0] {
      WO_NONE,
      WO_I,
      WO_BEST
   } wo_sel_type;

   // Result register load
   typedef enum logic [1:0] {
      EM_NONE,
      EM_ONE,
      EM_SORT
   } emit_type;

   // Controller to datapath
   typedef struct packed {
      logic       latch;
      logic       clr_tvalid;
      logic       release_slot;
      logic       clr_ovalid;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       scan_run;
      wt_sel_type wr_tag;
      wo_sel_type wr_org;
      logic       cap_org_i;
      logic       next_i;
      logic       pos_init;
      logic       pos_step;
      emit_type   emit;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;
      logic is_sort;
      logic scan_hit;
      logic scan_done;
      logic swap_need;
      logic sort_end;
      logic pos_last;
   } dp_sts_type;

endpackage

@@ design/spas_ram.sv @@
module spas_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, register one read; hold read data when idle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/spas_dp.sv @@
module spas_dp #(
   parameter int SLOTS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [2:0]             req_command,
   input  logic [3:0]             req_type_tag,
   input  logic                   req_force_req,
   input  logic [3:0]             req_slot_index,
   input  spas_pkg::dp_cmd_type   cmd,
   output spas_pkg::dp_sts_type   sts,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic                   rsp_status,
   output logic [3:0]             rsp_slot_out,
   output logic [3:0]             rsp_tag_out,
   output logic [3:0]             rsp_source_slot,
   output logic                   rsp_last
);

   localparam int AW       = $clog2(SLOTS);
   localparam int CW       = $clog2(SLOTS + 1);
   localparam int IW       = (CW > 4) ? CW : 4;
   localparam int SORT_OUT = (SLOTS < 16) ? SLOTS : 16;

   // Latched request
   logic [2:0]     cmd_ff;
   logic [3:0]     tag_ff;
   logic           force_ff;
   logic [3:0]     idx_ff;
   logic           in_range_ff;

   // Scan and sort control
   logic [CW-1:0]  k_ff;
   logic           pv_ff;
   logic [AW-1:0]  pk_ff;
   logic           first_ff;
   logic [3:0]     bt_ff;
   logic [AW-1:0]  best_ff;
   logic [3:0]     tagi_ff;
   logic [AW-1:0]  i_ff;
   logic [3:0]     orgi_ff;
   logic           al_hit_ff;
   logic [AW-1:0]  al_slot_ff;
   logic [AW-1:0]  pos_ff;

   // Valid bits: an entry without one reads as free (tags) or identity (origins)
   logic [SLOTS-1:0] tvalid_ff;
   logic [SLOTS-1:0] ovalid_ff;

   // Read port state
   logic [AW-1:0]  rd_addr_ff;
   logic           tv_ff;
   logic           ov_ff;

   // Result register
   logic           rsp_valid_ff;
   logic           rsp_status_ff;
   logic [3:0]     rsp_slot_ff;
   logic [3:0]     rsp_tag_ff;
   logic [3:0]     rsp_src_ff;
   logic           rsp_last_ff;

   logic [AW-1:0]  req_addr;
   logic           req_in_range;
   logic [CW-1:0]  lim;
   logic           k_lt_lim;
   logic           rd_go;
   logic [AW-1:0]  rd_addr;
   logic [3:0]     tag_rdata;
   logic [3:0]     org_rdata;
   logic [3:0]     eff_tag;
   logic [3:0]     eff_org;
   logic           tw_en;
   logic [AW-1:0]  tw_addr;
   logic [3:0]     tw_data;
   logic           ow_en;
   logic [AW-1:0]  ow_addr;
   logic [3:0]     ow_data;
   logic           scan_hit;
   logic           one_status;
   logic [3:0]     one_slot;
   logic [3:0]     one_tag;

   assign req_addr     = AW'(req_slot_index);
   assign req_in_range = IW'(req_slot_index) < IW'(SLOTS);

   // Allocate without force skips the two reserved slots at the top
   assign lim      = (cmd_ff == spas_pkg::CMD_ALLOC && !force_ff) ? CW'(SLOTS - 2) : CW'(SLOTS);
   assign k_lt_lim = k_ff < lim;

   // Pick the read address
   always_comb begin
      rd_go   = cmd.rd_en | (cmd.scan_run & k_lt_lim);
      rd_addr = AW'(k_ff);
      if (!cmd.scan_run) begin
         case (cmd.rd_sel)
            spas_pkg::RD_IDX:  rd_addr = req_addr;
            spas_pkg::RD_I:    rd_addr = i_ff;
            spas_pkg::RD_BEST: rd_addr = best_ff;
            spas_pkg::RD_POS:  rd_addr = pos_ff;
            default:           rd_addr = req_addr;
         endcase
      end
   end

   assign eff_tag  = tv_ff ? tag_rdata : spas_pkg::FREE_TAG;
   assign eff_org  = ov_ff ? org_rdata : 4'(rd_addr_ff);
   assign scan_hit = pv_ff && (eff_tag == spas_pkg::FREE_TAG) &&
                     (cmd_ff == spas_pkg::CMD_ALLOC);

   // Select tag table writes
   always_comb begin
      tw_en   = 1'b1;
      tw_addr = pk_ff;
      tw_data = tag_ff;
      case (cmd.wr_tag)
         spas_pkg::WT_ALLOC: begin
            tw_addr = pk_ff;
            tw_data = tag_ff;
         end
         spas_pkg::WT_I: begin
            tw_addr = i_ff;
            tw_data = bt_ff;
         end
         spas_pkg::WT_BEST: begin
            tw_addr = best_ff;
            tw_data = tagi_ff;
         end
         default: tw_en = 1'b0;
      endcase
   end

   // Select origin table writes
   always_comb begin
      ow_en   = 1'b1;
      ow_addr = i_ff;
      ow_data = eff_org;
      case (cmd.wr_org)
         spas_pkg::WO_I: begin
            ow_addr = i_ff;
            ow_data = eff_org;
         end
         spas_pkg::WO_BEST: begin
            ow_addr = best_ff;
            ow_data = orgi_ff;
         end
         default: ow_en = 1'b0;
      endcase
   end

   spas_ram #(.WIDTH(4), .DEPTH(SLOTS)) u_tag_ram (
      .clock   (clock),
      .wr_en   (tw_en),
      .wr_addr (tw_addr),
      .wr_data (tw_data),
      .rd_en   (rd_go),
      .rd_addr (rd_addr),
      .rd_data (tag_rdata)
   );

   spas_ram #(.WIDTH(4), .DEPTH(SLOTS)) u_org_ram (
      .clock   (clock),
      .wr_en   (ow_en),
      .wr_addr (ow_addr),
      .wr_data (ow_data),
      .rd_en   (rd_go),
      .rd_addr (rd_addr),
      .rd_data (org_rdata)
   );

   // Track which entries hold a written value
   always_ff @(posedge clock) begin
      if (reset) begin
         tvalid_ff <= '0;
         ovalid_ff <= '0;
      end else begin
         if (cmd.clr_tvalid) begin
            tvalid_ff <= '0;
         end else if (cmd.release_slot && req_in_range) begin
            tvalid_ff[req_addr] <= 1'b0;
         end else if (tw_en) begin
            tvalid_ff[tw_addr] <= 1'b1;
         end
         if (cmd.clr_ovalid) begin
            ovalid_ff <= '0;
         end else if (ow_en) begin
            ovalid_ff[ow_addr] <= 1'b1;
         end
      end
   end

   // Register the read address with the valid bits it sees
   always_ff @(posedge clock) begin
      if (rd_go) begin
         rd_addr_ff <= rd_addr;
         tv_ff      <= (CW'(rd_addr) < CW'(SLOTS)) & tvalid_ff[rd_addr];
         ov_ff      <= (CW'(rd_addr) < CW'(SLOTS)) & ovalid_ff[rd_addr];
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cmd_ff      <= req_command;
         tag_ff      <= req_type_tag;
         force_ff    <= req_force_req;
         idx_ff      <= req_slot_index;
         in_range_ff <= req_in_range;
      end
   end

   // Advance the scan, track the first minimum and the first free slot
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff      <= '0;
         pv_ff     <= 1'b0;
         first_ff  <= 1'b1;
         i_ff      <= '0;
         al_hit_ff <= 1'b0;
         pos_ff    <= '0;
      end else begin
         if (cmd.latch) begin
            k_ff      <= '0;
            pv_ff     <= 1'b0;
            first_ff  <= 1'b1;
            i_ff      <= '0;
            al_hit_ff <= 1'b0;
         end else if (cmd.next_i) begin
            i_ff     <= i_ff + 1'b1;
            k_ff     <= CW'(i_ff) + 1'b1;
            pv_ff    <= 1'b0;
            first_ff <= 1'b1;
         end else if (cmd.scan_run) begin
            k_ff  <= k_ff + CW'(k_lt_lim);
            pv_ff <= k_lt_lim;
            if (pv_ff) begin
               first_ff <= 1'b0;
            end
            if (scan_hit) begin
               al_hit_ff <= 1'b1;
            end
         end
         if (cmd.pos_init) begin
            pos_ff <= '0;
         end else if (cmd.pos_step) begin
            pos_ff <= pos_ff + 1'b1;
         end
      end
   end

   // Hold scan payload
   always_ff @(posedge clock) begin
      if (cmd.scan_run) begin
         pk_ff <= AW'(k_ff);
         if (pv_ff && (first_ff || eff_tag < bt_ff)) begin
            bt_ff   <= eff_tag;
            best_ff <= pk_ff;
         end
         if (pv_ff && first_ff) begin
            tagi_ff <= eff_tag;
         end
         if (scan_hit) begin
            al_slot_ff <= pk_ff;
         end
      end
      if (cmd.cap_org_i) begin
         orgi_ff <= eff_org;
      end
   end

   // Build a single-beat result
   always_comb begin
      one_status = 1'b0;
      one_slot   = 4'd0;
      one_tag    = 4'd0;
      case (cmd_ff)
         spas_pkg::CMD_CLEAR: begin
            one_tag = spas_pkg::FREE_TAG;
         end
         spas_pkg::CMD_ALLOC: begin
            if (al_hit_ff) begin
               one_slot = 4'(al_slot_ff);
               one_tag  = tag_ff;
            end else begin
               one_status = 1'b1;
               one_tag    = spas_pkg::FREE_TAG;
            end
         end
         spas_pkg::CMD_RELEASE: begin
            one_slot = idx_ff;
            one_tag  = spas_pkg::FREE_TAG;
         end
         spas_pkg::CMD_READ: begin
            one_slot = idx_ff;
            one_tag  = in_range_ff ? eff_tag : spas_pkg::FREE_TAG;
         end
         default: begin
            one_status = 1'b0;
         end
      endcase
   end

   // Load the result register, drop valid once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit != spas_pkg::EM_NONE) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.emit)
         spas_pkg::EM_ONE: begin
            rsp_status_ff <= one_status;
            rsp_slot_ff   <= one_slot;
            rsp_tag_ff    <= one_tag;
            rsp_src_ff    <= 4'd0;
            rsp_last_ff   <= 1'b1;
         end
         spas_pkg::EM_SORT: begin
            rsp_status_ff <= 1'b0;
            rsp_slot_ff   <= 4'(pos_ff);
            rsp_tag_ff    <= eff_tag;
            rsp_src_ff    <= eff_org;
            rsp_last_ff   <= sts.pos_last;
         end
         default: begin
            rsp_status_ff <= rsp_status_ff;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_out    = rsp_slot_ff;
   assign rsp_tag_out     = rsp_tag_ff;
   assign rsp_source_slot = rsp_src_ff;
   assign rsp_last        = rsp_last_ff;

   // Report status
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;
   assign sts.is_sort   = cmd_ff == spas_pkg::CMD_SORT;
   assign sts.scan_hit  = scan_hit;
   assign sts.scan_done = !pv_ff && !k_lt_lim;
   assign sts.swap_need = best_ff != i_ff;
   assign sts.sort_end  = i_ff == AW'(SLOTS - 2);
   assign sts.pos_last  = pos_ff == AW'(SORT_OUT - 1);

endmodule

@@ design/spas_ctrl.sv @@
module spas_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [2:0]             req_command,
   output logic                   req_stall,
   output spas_pkg::dp_cmd_type   cmd,
   input  spas_pkg::dp_sts_type   sts
);

   spas_pkg::state_type state_ff;
   spas_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spas_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spas_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_command)
                  spas_pkg::CMD_ALLOC, spas_pkg::CMD_SORT: state_in = spas_pkg::ST_SCAN;
                  default:                                 state_in = spas_pkg::ST_ONE;
               endcase
            end
         end
         spas_pkg::ST_ONE: begin
            if (sts.out_free) begin
               state_in = spas_pkg::ST_IDLE;
            end
         end
         spas_pkg::ST_SCAN: begin
            if (!sts.is_sort) begin
               if (sts.scan_hit || sts.scan_done) begin
                  state_in = spas_pkg::ST_ONE;
               end
            end else if (sts.scan_done) begin
               state_in = sts.swap_need ? spas_pkg::ST_SWAP_A : spas_pkg::ST_NEXT;
            end
         end
         spas_pkg::ST_SWAP_A: state_in = spas_pkg::ST_SWAP_B;
         spas_pkg::ST_SWAP_B: state_in = spas_pkg::ST_SWAP_C;
         spas_pkg::ST_SWAP_C: state_in = spas_pkg::ST_SWAP_D;
         spas_pkg::ST_SWAP_D: state_in = spas_pkg::ST_NEXT;
         spas_pkg::ST_NEXT: begin
            state_in = sts.sort_end ? spas_pkg::ST_POS_RD : spas_pkg::ST_SCAN;
         end
         spas_pkg::ST_POS_RD: state_in = spas_pkg::ST_POS_EM;
         spas_pkg::ST_POS_EM: begin
            if (sts.out_free) begin
               state_in = sts.pos_last ? spas_pkg::ST_IDLE : spas_pkg::ST_POS_RD;
            end
         end
         default: state_in = spas_pkg::ST_IDLE;
      endcase
   end

   // Datapath commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         spas_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.latch = 1'b1;
               case (req_command)
                  spas_pkg::CMD_CLEAR:   cmd.clr_tvalid   = 1'b1;
                  spas_pkg::CMD_RELEASE: cmd.release_slot = 1'b1;
                  spas_pkg::CMD_SORT:    cmd.clr_ovalid   = 1'b1;
                  spas_pkg::CMD_READ: begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = spas_pkg::RD_IDX;
                  end
                  default: cmd.latch = 1'b1;
               endcase
            end
         end
         spas_pkg::ST_ONE: begin
            if (sts.out_free) begin
               cmd.emit = spas_pkg::EM_ONE;
            end
         end
         spas_pkg::ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (!sts.is_sort && sts.scan_hit) begin
               cmd.wr_tag = spas_pkg::WT_ALLOC;
            end
         end
         spas_pkg::ST_SWAP_A: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = spas_pkg::RD_I;
            cmd.wr_tag = spas_pkg::WT_I;
         end
         spas_pkg::ST_SWAP_B: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = spas_pkg::RD_BEST;
            cmd.cap_org_i = 1'b1;
            cmd.wr_tag    = spas_pkg::WT_BEST;
         end
         spas_pkg::ST_SWAP_C: cmd.wr_org = spas_pkg::WO_I;
         spas_pkg::ST_SWAP_D: cmd.wr_org = spas_pkg::WO_BEST;
         spas_pkg::ST_NEXT: begin
            if (sts.sort_end) begin
               cmd.pos_init = 1'b1;
            end else begin
               cmd.next_i = 1'b1;
            end
         end
         spas_pkg::ST_POS_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = spas_pkg::RD_POS;
         end
         spas_pkg::ST_POS_EM: begin
            if (sts.out_free) begin
               cmd.emit     = spas_pkg::EM_SORT;
               cmd.pos_step = !sts.pos_last;
            end
         end
         default: req_stall = 1'b1;
      endcase
   end

endmodule

@@ design/slot_pool_allocate_sort.sv @@
// Slot pool with first-fit allocate, release, read, clear and an in-place
// selection sort by tag. One request is worked at a time; a new request is
// taken whenever the block is idle, even while the previous result still sits
// in the output register. Clear, release, read and unknown commands emit one
// result from the ONE state. Allocate walks the tag table one slot a cycle
// through its single read port. Sort runs one scan per position, a swap
// (states SWAP_A to SWAP_D) where needed and a step state, then reports each
// position through a read state and an emit state. Valid bits stand for the
// reset contents, so no clearing pass follows reset.
module slot_pool_allocate_sort #(
   parameter int SLOTS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_command,
   input  logic [3:0] req_type_tag,
   input  logic       req_force_req,
   input  logic [3:0] req_slot_index,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_status,
   output logic [3:0] rsp_slot_out,
   output logic [3:0] rsp_tag_out,
   output logic [3:0] rsp_source_slot,
   output logic       rsp_last
);

   spas_pkg::dp_cmd_type dp_cmd;
   spas_pkg::dp_sts_type dp_sts;

   spas_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .cmd         (dp_cmd),
      .sts         (dp_sts)
   );

   spas_dp #(.SLOTS(SLOTS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_command     (req_command),
      .req_type_tag    (req_type_tag),
      .req_force_req   (req_force_req),
      .req_slot_index  (req_slot_index),
      .cmd             (dp_cmd),
      .sts             (dp_sts),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_slot_out    (rsp_slot_out),
      .rsp_tag_out     (rsp_tag_out),
      .rsp_source_slot (rsp_source_slot),
      .rsp_last        (rsp_last)
   );

endmodule

@@ design/spas_check.sv @@
`include "slot_pool_allocate_sort_macros.svh"

module spas_check (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_status,
   input logic [3:0] rsp_slot_out,
   input logic [3:0] rsp_tag_out,
   input logic [3:0] rsp_source_slot,
   input logic       rsp_last
);

   logic [13:0] rsp_beat;
   logic        full_shape;

   // Gather the result payload and the shape of a full-pool answer
   assign rsp_beat   = {rsp_status, rsp_slot_out, rsp_tag_out, rsp_source_slot, rsp_last};
   assign full_shape = rsp_last && (rsp_slot_out == 4'd0) &&
                       (rsp_tag_out == spas_pkg::FREE_TAG) && (rsp_source_slot == 4'd0);

   // Hold a stalled result beat
   `SPAS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_beat))

   // A full pool answers with one free, zero-slot beat
   `SPAS_ASSERT_SAME(a_full_shape, rsp_valid && rsp_status, full_shape)

   // Stall new requests while one is being worked
   `SPAS_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

   // Beats before the last one, which only sort gives, never report full
   `SPAS_ASSERT_SAME(a_multi_is_sort, rsp_valid && !rsp_last, !rsp_status)

endmodule

bind slot_pool_allocate_sort spas_check u_spas_check (.*);

@@ dv/tb_slot_pool_allocate_sort.sv @@
`timescale 1ns / 1ps

module tb_slot_pool_allocate_sort;

   localparam int POOL_SLOTS   = 16;
   localparam int RESERVED_TOP = 2;
   localparam int RANDOM_ITEMS = 410;
   localparam int SETTLE_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 1_000_000;

   // Command codes the block answers with a zero beat that has last set
   localparam logic [2:0] CMD_SPARE_A = 3'd5;
   localparam logic [2:0] CMD_SPARE_B = 3'd6;
   localparam logic [2:0] CMD_SPARE_C = 3'd7;

   // Receiver stall patterns
   localparam int RX_OPEN   = 0;
   localparam int RX_COIN   = 1;
   localparam int RX_CLUMPS = 2;

   typedef struct {
      logic [2:0] cmd;
      logic [3:0] tag;
      logic       force_req;
      logic [3:0] idx;
      bit         drain_first;
   } pool_cmd_type;

   typedef struct {
      logic       status;
      logic [3:0] slot;
      logic [3:0] tag;
      logic [3:0] src;
      logic       last;
   } slot_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_command = '0;
   logic [3:0] req_type_tag = '0;
   logic       req_force_req = 1'b0;
   logic [3:0] req_slot_index = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_status;
   logic [3:0] rsp_slot_out;
   logic [3:0] rsp_tag_out;
   logic [3:0] rsp_source_slot;
   logic       rsp_last;

   // Shadow copy of the pool
   logic [3:0] pool_tags [POOL_SLOTS];
   logic [3:0] pool_origin [POOL_SLOTS];

   pool_cmd_type    cmd_backlog[$];
   slot_result_type slot_results_due[$];
   pool_cmd_type    on_wire;

   int fail_count = 0;
   int queued_count = 0;
   int sent_count = 0;
   int cycle_count = 0;
   int burst_left = 1;
   int gap_left = 0;
   int stall_mode = RX_OPEN;
   int mode_left = 0;
   int clump_left = 0;

   slot_pool_allocate_sort #(
      .SLOTS(POOL_SLOTS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_type_tag(req_type_tag),
      .req_force_req(req_force_req),
      .req_slot_index(req_slot_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_slot_out(rsp_slot_out),
      .rsp_tag_out(rsp_tag_out),
      .rsp_source_slot(rsp_source_slot),
      .rsp_last(rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void due_result(logic status, logic [3:0] slot, logic [3:0] tag,
                                      logic [3:0] src, logic last);
      slot_result_type r;
      r.status = status;
      r.slot   = slot;
      r.tag    = tag;
      r.src    = src;
      r.last   = last;
      slot_results_due.push_back(r);
   endfunction

   // Advance the shadow pool by one command and queue the beats it yields
   function automatic void apply_pool_command(pool_cmd_type c);
      int         limit;
      int         best;
      logic [3:0] best_tag;
      logic [3:0] t;
      bit         placed;
      placed = 1'b0;
      case (c.cmd)
         spas_pkg::CMD_CLEAR: begin
            foreach (pool_tags[i]) pool_tags[i] = spas_pkg::FREE_TAG;
            due_result(1'b0, 4'd0, spas_pkg::FREE_TAG, 4'd0, 1'b1);
         end
         spas_pkg::CMD_ALLOC: begin
            limit = c.force_req ? POOL_SLOTS : POOL_SLOTS - RESERVED_TOP;
            for (int i = 0; i < limit && !placed; i++) begin
               if (pool_tags[i] == spas_pkg::FREE_TAG) begin
                  pool_tags[i] = c.tag;
                  due_result(1'b0, 4'(i), c.tag, 4'd0, 1'b1);
                  placed = 1'b1;
               end
            end
            if (!placed) due_result(1'b1, 4'd0, spas_pkg::FREE_TAG, 4'd0, 1'b1);
         end
         spas_pkg::CMD_RELEASE: begin
            if (int'(c.idx) < POOL_SLOTS) pool_tags[c.idx] = spas_pkg::FREE_TAG;
            due_result(1'b0, c.idx, spas_pkg::FREE_TAG, 4'd0, 1'b1);
         end
         spas_pkg::CMD_SORT: begin
            foreach (pool_origin[i]) pool_origin[i] = 4'(i);
            // Selection sort: first minimum at or after each position wins
            for (int i = 0; i < POOL_SLOTS; i++) begin
               best = i;
               best_tag = pool_tags[i];
               for (int j = i + 1; j < POOL_SLOTS; j++) begin
                  if (pool_tags[j] < best_tag) begin
                     best_tag = pool_tags[j];
                     best = j;
                  end
               end
               if (best != i) begin
                  t = pool_tags[i];
                  pool_tags[i] = pool_tags[best];
                  pool_tags[best] = t;
                  t = pool_origin[i];
                  pool_origin[i] = pool_origin[best];
                  pool_origin[best] = t;
               end
            end
            for (int i = 0; i < POOL_SLOTS && i < 16; i++) begin
               due_result(1'b0, 4'(i), pool_tags[i], pool_origin[i],
                          (i + 1 == POOL_SLOTS || i == 15));
            end
         end
         spas_pkg::CMD_READ: begin
            due_result(1'b0, c.idx,
                       (int'(c.idx) < POOL_SLOTS) ? pool_tags[c.idx] : spas_pkg::FREE_TAG,
                       4'd0, 1'b1);
         end
         default: begin
            due_result(1'b0, 4'd0, 4'd0, 4'd0, 1'b1);
         end
      endcase
   endfunction

   function automatic void queue_cmd(logic [2:0] cmd, logic [3:0] tag, logic force_req,
                                     logic [3:0] idx);
      pool_cmd_type c;
      c.cmd = cmd;
      c.tag = tag;
      c.force_req = force_req;
      c.idx = idx;
      // Every so often hold the sender until the pool has answered everything
      c.drain_first = (queued_count % 137 == 136);
      cmd_backlog.push_back(c);
      queued_count++;
   endfunction

   function automatic logic [3:0] pick_tag();
      return ($urandom_range(0, 9) == 0) ? spas_pkg::FREE_TAG : 4'($urandom_range(0, 14));
   endfunction

   function automatic logic [3:0] pick_slot();
      return 4'($urandom_range(0, 15));
   endfunction

   // Stimulus: directed opening, then random sequences; wait out the tail
   initial begin
      int         kind;
      int         n;
      int         sel;
      int         random_start;
      logic [2:0] c;

      foreach (pool_tags[i]) begin
         pool_tags[i] = spas_pkg::FREE_TAG;
         pool_origin[i] = 4'(i);
      end

      queue_cmd(spas_pkg::CMD_READ, 4'd0, 1'b0, 4'd0);
      queue_cmd(spas_pkg::CMD_SORT, 4'd0, 1'b0, 4'd0);
      queue_cmd(spas_pkg::CMD_ALLOC, 4'd14, 1'b0, 4'd15);
      queue_cmd(spas_pkg::CMD_ALLOC, 4'd0, 1'b1, 4'd0);
      queue_cmd(spas_pkg::CMD_ALLOC, spas_pkg::FREE_TAG, 1'b0, 4'd3);
      queue_cmd(spas_pkg::CMD_READ, 4'd0, 1'b0, 4'd2);
      queue_cmd(spas_pkg::CMD_ALLOC, 4'd7, 1'b1, 4'd9);
      queue_cmd(spas_pkg::CMD_READ, 4'd15, 1'b1, 4'd15);
      queue_cmd(spas_pkg::CMD_RELEASE, 4'd0, 1'b0, 4'd15);
      queue_cmd(spas_pkg::CMD_RELEASE, 4'd15, 1'b1, 4'd0);
      queue_cmd(spas_pkg::CMD_READ, 4'd0, 1'b0, 4'd0);
      queue_cmd(spas_pkg::CMD_ALLOC, 4'd3, 1'b0, 4'd0);
      queue_cmd(spas_pkg::CMD_SORT, 4'd15, 1'b1, 4'd15);
      queue_cmd(CMD_SPARE_A, 4'd15, 1'b1, 4'd15);
      queue_cmd(CMD_SPARE_B, 4'd0, 1'b0, 4'd0);
      queue_cmd(CMD_SPARE_C, 4'd10, 1'b1, 4'd5);
      queue_cmd(spas_pkg::CMD_CLEAR, 4'd15, 1'b1, 4'd15);
      queue_cmd(spas_pkg::CMD_READ, 4'd0, 1'b0, 4'd1);

      random_start = queued_count;
      while (queued_count - random_start < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         if (kind <= 3) begin
            // Fill the pool, often past the reserved limit, then mostly sort it
            if ($urandom_range(0, 1) == 1)
               queue_cmd(spas_pkg::CMD_CLEAR, pick_tag(), 1'($urandom), pick_slot());
            n = $urandom_range(4, 18);
            repeat (n) queue_cmd(spas_pkg::CMD_ALLOC, pick_tag(), ($urandom_range(0, 2) == 0),
                                 pick_slot());
            if ($urandom_range(0, 9) < 7)
               queue_cmd(spas_pkg::CMD_SORT, pick_tag(), 1'($urandom), pick_slot());
         end else if (kind <= 6) begin
            // Churn: mixed allocate, release and read
            n = $urandom_range(4, 12);
            repeat (n) begin
               sel = $urandom_range(0, 2);
               c = (sel == 0) ? spas_pkg::CMD_ALLOC :
                   (sel == 1) ? spas_pkg::CMD_RELEASE : spas_pkg::CMD_READ;
               queue_cmd(c, pick_tag(), 1'($urandom), pick_slot());
            end
         end else if (kind == 7) begin
            queue_cmd(spas_pkg::CMD_SORT, pick_tag(), 1'($urandom), pick_slot());
         end else begin
            // Noise, spare codes included
            n = $urandom_range(1, 4);
            repeat (n) queue_cmd(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                                 1'($urandom), pick_slot());
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (sent_count < queued_count) @(posedge clock);
      while (slot_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Sender: bursts of beats separated by random gaps
   always @(posedge clock) begin : sender
      logic nxt_valid;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 1;
         gap_left = 0;
      end else begin
         nxt_valid = req_valid;
         if (req_valid && !req_stall) begin
            apply_pool_command(on_wire);
            sent_count++;
            nxt_valid = 1'b0;
         end
         if (!nxt_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (cmd_backlog.size() != 0 &&
                         !(cmd_backlog[0].drain_first && slot_results_due.size() != 0)) begin
               on_wire = cmd_backlog.pop_front();
               req_command    <= on_wire.cmd;
               req_type_tag   <= on_wire.tag;
               req_force_req  <= on_wire.force_req;
               req_slot_index <= on_wire.idx;
               nxt_valid = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
         req_valid <= nxt_valid;
      end
   end

   // Receiver: switch between open, coin-flip and clumped stall patterns
   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_stall <= 1'b0;
         mode_left = 0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(RX_OPEN, RX_CLUMPS);
            mode_left = $urandom_range(16, 96);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            RX_OPEN: rsp_stall <= 1'b0;
            RX_COIN: rsp_stall <= 1'($urandom_range(0, 1));
            default: begin
               if (clump_left > 0) begin
                  clump_left--;
                  rsp_stall <= 1'b1;
               end else if ($urandom_range(0, 5) == 0) begin
                  clump_left = $urandom_range(1, 7);
                  rsp_stall <= 1'b1;
               end else begin
                  rsp_stall <= 1'b0;
               end
            end
         endcase
      end
   end

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Monitor: compare each accepted beat with the oldest expectation
   always @(posedge clock) begin : monitor
      slot_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (slot_results_due.size() == 0) begin
            $error("result beat with nothing outstanding: slot_out %0d tag_out %0d",
                   rsp_slot_out, rsp_tag_out);
            fail_count++;
         end else begin
            want = slot_results_due.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("slot_out", want.slot, rsp_slot_out);
            check_field("tag_out", want.tag, rsp_tag_out);
            check_field("source_slot", want.src, rsp_source_slot);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule

@@ filelist.f @@
+incdir+design
design/spas_pkg.sv
design/spas_ram.sv
design/spas_dp.sv
design/spas_ctrl.sv
design/slot_pool_allocate_sort.sv
design/spas_check.sv
dv/tb_slot_pool_allocate_sort.sv
